/* hdl/newton_cotes_integrator_assert.svh */
// assertion macros shared by the integrator rtl
`ifndef NEWTON_COTES_INTEGRATOR_ASSERT_SVH
`define NEWTON_COTES_INTEGRATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define NCI_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define NCI_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/nci_pkg.sv */
`default_nettype none

package nci_pkg;

	localparam int WEIGHT_FRAC_BITS = 24;
	localparam int PANEL_COUNT_BITS = 16;
	localparam int MAX_NODES        = 7;

	localparam int SAMPLE_W  = 32;
	localparam int METHOD_W  = 3;
	localparam int NODE_W    = $clog2(MAX_NODES + 1);
	localparam int PC_W      = (PANEL_COUNT_BITS < 16) ? PANEL_COUNT_BITS : 16;
	localparam int SUM_W     = 64;
	localparam int OUT_W     = 48;
	// product of sample and weight, rounded half up to 24 fraction bits
	localparam int PROD_W    = SAMPLE_W + WEIGHT_FRAC_BITS + 1;
	localparam int RND_SHIFT = WEIGHT_FRAC_BITS - 8;
	localparam int ADD_W     = PROD_W - RND_SHIFT;
	// sum (24 frac) times width (16 frac) back to 16 frac
	localparam int FIN_SHIFT = 24;
	localparam int HI_TOP    = OUT_W - 1 - (32 - FIN_SHIFT);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// rule codes
	localparam logic [METHOD_W-1:0] M_TRAP    = 3'd1;
	localparam logic [METHOD_W-1:0] M_SIMPSON = 3'd2;
	localparam logic [METHOD_W-1:0] M_38      = 3'd3;
	localparam logic [METHOD_W-1:0] M_BOOLE   = 3'd4;
	localparam logic [METHOD_W-1:0] M_FIVE    = 3'd5;
	localparam logic [METHOD_W-1:0] M_WEDDLE  = 3'd6;

	typedef enum logic [1:0] {
		REG_METHOD      = 2'd0,
		REG_PANEL_COUNT = 2'd1,
		REG_PANEL_WIDTH = 2'd2
	} reg_idx_t;

	// weights, round half up
	localparam logic [63:0] W_1_2    = ((64'd1 << WEIGHT_FRAC_BITS) + 64'd1) / 64'd2;
	localparam logic [63:0] W_1_6    = ((64'd1 << WEIGHT_FRAC_BITS) + 64'd3) / 64'd6;
	localparam logic [63:0] W_4_6    = ((64'd4 << WEIGHT_FRAC_BITS) + 64'd3) / 64'd6;
	localparam logic [63:0] W_1_8    = ((64'd1 << WEIGHT_FRAC_BITS) + 64'd4) / 64'd8;
	localparam logic [63:0] W_3_8    = ((64'd3 << WEIGHT_FRAC_BITS) + 64'd4) / 64'd8;
	localparam logic [63:0] W_7_90   = ((64'd7 << WEIGHT_FRAC_BITS) + 64'd45) / 64'd90;
	localparam logic [63:0] W_32_90  = ((64'd32 << WEIGHT_FRAC_BITS) + 64'd45) / 64'd90;
	localparam logic [63:0] W_12_90  = ((64'd12 << WEIGHT_FRAC_BITS) + 64'd45) / 64'd90;
	localparam logic [63:0] W_19_288 = ((64'd19 << WEIGHT_FRAC_BITS) + 64'd144) / 64'd288;
	localparam logic [63:0] W_75_288 = ((64'd75 << WEIGHT_FRAC_BITS) + 64'd144) / 64'd288;
	localparam logic [63:0] W_50_288 = ((64'd50 << WEIGHT_FRAC_BITS) + 64'd144) / 64'd288;
	localparam logic [63:0] W_41_840  = ((64'd41 << WEIGHT_FRAC_BITS) + 64'd420) / 64'd840;
	localparam logic [63:0] W_216_840 = ((64'd216 << WEIGHT_FRAC_BITS) + 64'd420) / 64'd840;
	localparam logic [63:0] W_27_840  = ((64'd27 << WEIGHT_FRAC_BITS) + 64'd420) / 64'd840;
	localparam logic [63:0] W_272_840 = ((64'd272 << WEIGHT_FRAC_BITS) + 64'd420) / 64'd840;

	typedef struct packed {
		logic [METHOD_W-1:0] method;
		logic [PC_W-1:0]     panel_count;
		logic signed [31:0]  panel_width;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0]   sample;
		logic [WEIGHT_FRAC_BITS-1:0]  weight;
		logic                         last;
	} q_item_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] sum;
		logic             ovf;
	} fin_req_t;

	function automatic logic [WEIGHT_FRAC_BITS-1:0] node_weight(
		input logic [METHOD_W-1:0] m,
		input logic [NODE_W-1:0]   k
	);
		logic [63:0] w;
		w = '0;
		case (m)
			M_TRAP: begin
				case (k)
					3'd0, 3'd1: w = W_1_2;
					default:    w = '0;
				endcase
			end
			M_SIMPSON: begin
				case (k)
					3'd0, 3'd2: w = W_1_6;
					3'd1:       w = W_4_6;
					default:    w = '0;
				endcase
			end
			M_38: begin
				case (k)
					3'd0, 3'd3: w = W_1_8;
					3'd1, 3'd2: w = W_3_8;
					default:    w = '0;
				endcase
			end
			M_BOOLE: begin
				case (k)
					3'd0, 3'd4: w = W_7_90;
					3'd1, 3'd3: w = W_32_90;
					3'd2:       w = W_12_90;
					default:    w = '0;
				endcase
			end
			M_FIVE: begin
				case (k)
					3'd0, 3'd5: w = W_19_288;
					3'd1, 3'd4: w = W_75_288;
					3'd2, 3'd3: w = W_50_288;
					default:    w = '0;
				endcase
			end
			M_WEDDLE: begin
				case (k)
					3'd0, 3'd6: w = W_41_840;
					3'd1, 3'd5: w = W_216_840;
					3'd2, 3'd4: w = W_27_840;
					3'd3:       w = W_272_840;
					default:    w = '0;
				endcase
			end
			default: w = '0;
		endcase
		return w[WEIGHT_FRAC_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

/* hdl/nci_front.sv */
`default_nettype none

module nci_front import nci_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire cfg_t                       cfg,
	input  wire logic                       sample_valid,
	output logic                            sample_ready,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	output logic                            item_valid,
	input  wire logic                       item_ready,
	output q_item_t                         item
);

	logic [NODE_W-1:0] node_q;
	logic [PC_W-1:0]   panel_q;
	logic [PC_W-1:0]   panels;
	logic              last_node;
	logic              last_panel;
	logic              accept;

	assign sample_ready = item_ready;
	assign item_valid   = sample_valid;
	assign accept       = sample_valid && item_ready;

	// zero panels counts as one
	assign panels     = (cfg.panel_count == '0) ? PC_W'(1) : cfg.panel_count;
	assign last_node  = !(node_q < cfg.method);
	assign last_panel = ({1'b0, panel_q} + (PC_W+1)'(1)) >= {1'b0, panels};

	assign item.sample = sample;
	assign item.weight = node_weight(cfg.method, node_q);
	assign item.last   = last_node && last_panel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q  <= '0;
			panel_q <= '0;
		end else if (accept) begin
			if (last_node) begin
				node_q <= '0;
				if (last_panel) begin
					panel_q <= '0;
				end else begin
					panel_q <= panel_q + PC_W'(1);
				end
			end else begin
				node_q <= node_q + NODE_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/nci_fifo.sv */
`default_nettype none

module nci_fifo import nci_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push_valid,
	output logic         push_ready,
	input  wire q_item_t push_item,
	output logic         pop_valid,
	input  wire logic    pop_ready,
	output q_item_t      pop_item
);

	q_item_t            mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               push;
	logic               pop;

	assign push_ready = cnt_q != (FIFO_AW+1)'(FIFO_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_item   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + FIFO_AW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (FIFO_AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (FIFO_AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/nci_mac.sv */
`default_nettype none

module nci_mac import nci_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    pop_valid,
	output logic         pop_ready,
	input  wire q_item_t pop_item,
	input  wire logic    fin_busy,
	output fin_req_t     fin_req
);

	localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (RND_SHIFT - 1);
	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	logic signed [PROD_W-1:0] prod_s1;
	logic                     last_s1;
	logic                     v_s1;
	logic signed [ADD_W-1:0]  rnd_s2;
	logic                     last_s2;
	logic                     v_s2;
	logic [SUM_W-1:0]         sum_q;
	logic                     ovf_q;

	logic signed [PROD_W-1:0] rnd_full;
	logic signed [PROD_W-1:0] rnd_sh;
	logic [SUM_W:0]           sum_wide;
	logic                     ovfl;
	logic [SUM_W-1:0]         sum_sat;
	logic                     acc_fire;
	logic                     s2_load;
	logic                     s1_load;

	// an integral-closing sum waits until the scaler is free
	assign acc_fire  = v_s2 && (!last_s2 || !fin_busy);
	assign s2_load   = !v_s2 || acc_fire;
	assign s1_load   = !v_s1 || s2_load;
	assign pop_ready = s1_load;

	assign rnd_full = prod_s1 + RND_HALF;
	assign rnd_sh   = rnd_full >>> RND_SHIFT;

	assign sum_wide = {sum_q[SUM_W-1], sum_q}
		+ {{(SUM_W + 1 - ADD_W){rnd_s2[ADD_W-1]}}, rnd_s2};
	assign ovfl     = sum_wide[SUM_W] ^ sum_wide[SUM_W-1];
	assign sum_sat  = ovfl ? (sum_wide[SUM_W] ? SUM_MIN : SUM_MAX) : sum_wide[SUM_W-1:0];

	assign fin_req.start = acc_fire && last_s2;
	assign fin_req.sum   = sum_sat;
	assign fin_req.ovf   = ovf_q || ovfl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
			prod_s1 <= '0;
			rnd_s2  <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (s1_load) begin
				v_s1 <= pop_valid;
				if (pop_valid) begin
					prod_s1 <= $signed(pop_item.sample) * $signed({1'b0, pop_item.weight});
					last_s1 <= pop_item.last;
				end
			end
			if (s2_load) begin
				v_s2 <= v_s1;
				if (v_s1) begin
					rnd_s2  <= rnd_sh[ADD_W-1:0];
					last_s2 <= last_s1;
				end
			end
			if (acc_fire) begin
				if (last_s2) begin
					sum_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					sum_q <= sum_sat;
					ovf_q <= ovf_q || ovfl;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/nci_final.sv */
`default_nettype none

module nci_final import nci_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fin_req_t           fin_req,
	input  wire logic signed [31:0] panel_width,
	output logic                    busy,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output logic signed [OUT_W-1:0] integral,
	output logic                    saturated
);

	localparam logic [OUT_W:0] LIM_NEG = (OUT_W+1)'(1) << (OUT_W - 1);
	localparam logic [OUT_W:0] LIM_POS = LIM_NEG - (OUT_W+1)'(1);
	localparam logic [64:0]    LO_HALF = 65'(1) << (FIN_SHIFT - 1);

	typedef enum logic [2:0] {
		F_IDLE,
		F_MAG,
		F_MUL,
		F_SUM,
		F_NEG,
		F_OUT
	} fin_state_t;

	fin_state_t       state_q;
	logic [SUM_W-1:0] sum_q;
	logic             ovf_q;
	logic [SUM_W-1:0] mag_q;
	logic [31:0]      pw_q;
	logic             neg_q;
	logic [63:0]      hi_q;
	logic [63:0]      lo_q;
	logic [OUT_W-1:0] rcl_q;
	logic             sat_q;
	logic [OUT_W-1:0] integral_q;
	logic             saturated_q;

	logic [64:0]      lo_full;
	logic [64:0]      lo_sh;
	logic [OUT_W:0]   r;
	logic [OUT_W:0]   lim;
	logic             sat;

	assign busy         = state_q != F_IDLE;
	assign result_valid = state_q == F_OUT;
	assign integral     = $signed(integral_q);
	assign saturated    = saturated_q;

	assign lo_full = {1'b0, lo_q} + LO_HALF;
	assign lo_sh   = lo_full >> FIN_SHIFT;
	assign r       = (OUT_W+1)'({hi_q[HI_TOP-1:0], {(32 - FIN_SHIFT){1'b0}}})
		+ lo_sh[OUT_W:0];
	assign lim     = neg_q ? LIM_NEG : LIM_POS;
	assign sat     = (|hi_q[63:HI_TOP]) || (r > lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			mag_q       <= '0;
			pw_q        <= '0;
			neg_q       <= 1'b0;
			hi_q        <= '0;
			lo_q        <= '0;
			rcl_q       <= '0;
			sat_q       <= 1'b0;
			integral_q  <= '0;
			saturated_q <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (fin_req.start) begin
						sum_q   <= fin_req.sum;
						ovf_q   <= fin_req.ovf;
						state_q <= F_MAG;
					end
				end
				F_MAG: begin
					mag_q   <= sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;
					pw_q    <= panel_width[31] ? (32'd0 - panel_width) : panel_width;
					neg_q   <= sum_q[SUM_W-1] != panel_width[31];
					state_q <= F_MUL;
				end
				F_MUL: begin
					hi_q    <= mag_q[63:32] * pw_q;
					lo_q    <= mag_q[31:0] * pw_q;
					state_q <= F_SUM;
				end
				F_SUM: begin
					rcl_q   <= sat ? lim[OUT_W-1:0] : r[OUT_W-1:0];
					sat_q   <= sat;
					state_q <= F_NEG;
				end
				F_NEG: begin
					integral_q  <= neg_q ? (OUT_W'(0) - rcl_q) : rcl_q;
					saturated_q <= ovf_q || sat_q;
					state_q     <= F_OUT;
				end
				F_OUT: begin
					if (result_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/newton_cotes_integrator.sv */
// channel   direction  handshake                    payload
// cfg       in         cfg_valid / cfg_ready        cfg_index, cfg_data
// sample    in         sample_valid / sample_ready  sample (Q16.16)
// result    out        result_valid / result_ready  integral (Q32.16), saturated
//
// one sample per cycle within an integral while the queue is not backed up, set by the single multiply-accumulate lane
// a result is valid once its last sample transaction has passed the queue and multiply,
// round, accumulate, then four steps of the scaling sequencer
// the scaler takes one integral at a time, so an integral closes only once the result before it is taken
// reset clears the node and panel counters, the sum and the queue at once
// a closing sample stalls in the accumulator until the scaler is idle again, so an
// untaken result backs up the queue and then the sample input
`default_nettype none
`include "newton_cotes_integrator_assert.svh"

module newton_cotes_integrator import nci_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [31:0]                cfg_data,
	input  wire logic                       sample_valid,
	output logic                            sample_ready,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	output logic                            result_valid,
	input  wire logic                       result_ready,
	output logic signed [OUT_W-1:0]         integral,
	output logic                            saturated
);

	cfg_t     cfg_q;
	q_item_t  front_item;
	logic     front_valid;
	logic     front_ready;
	q_item_t  head_item;
	logic     head_valid;
	logic     head_ready;
	fin_req_t fin_req;
	logic     fin_busy;

	// registers are to change only while the block is idle (the block does not enforce this), so no write stall
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.method      <= M_SIMPSON;
			cfg_q.panel_count <= PC_W'(1);
			cfg_q.panel_width <= 32'sd65536;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_METHOD:      cfg_q.method      <= cfg_data[METHOD_W-1:0];
				REG_PANEL_COUNT: cfg_q.panel_count <= cfg_data[PC_W-1:0];
				REG_PANEL_WIDTH: cfg_q.panel_width <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// front: tracks node and panel position, looks up the weight, marks the closing sample
	nci_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.item_valid   (front_valid),
		.item_ready   (front_ready),
		.item         (front_item)
	);

	// short queue decouples sample intake from the accumulator
	nci_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_item  (front_item),
		.pop_valid  (head_valid),
		.pop_ready  (head_ready),
		.pop_item   (head_item)
	);

	// back: multiply, round to 24 fraction bits, saturating accumulate
	nci_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (head_valid),
		.pop_ready (head_ready),
		.pop_item  (head_item),
		.fin_busy  (fin_busy),
		.fin_req   (fin_req)
	);

	// scale by panel width, round, saturate, hold the result
	nci_final u_final (
		.clk          (clk),
		.arst_n       (arst_n),
		.fin_req      (fin_req),
		.panel_width  (cfg_q.panel_width),
		.busy         (fin_busy),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.integral     (integral),
		.saturated    (saturated)
	);

	`NCI_ASSERT_IMP(a_fin_start_idle, fin_req.start, !fin_busy, "scaler started while busy")
	`NCI_ASSERT_IMP(a_result_in_busy, result_valid, fin_busy, "result shown with scaler idle")
	`NCI_ASSERT_NXT(a_start_then_busy, fin_req.start, fin_busy && !result_valid, "scaler did not take the sum")

endmodule

`default_nettype wire
